// ===== rtl/ahbt_pkg.sv =====
`default_nettype none
package ahbt_pkg;

   typedef enum logic [1:0] {
      CMD_FLAG = 2'd0,
      CMD_DATA = 2'd1,
      CMD_FCS  = 2'd2,
      CMD_NONE = 2'd3
   } cmd_code_type;

   localparam logic [15:0] CRC_POLY    = 16'h8408;
   localparam logic [15:0] CRC_PRESET  = 16'hFFFF;
   localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
   localparam logic [7:0]  BYTE_MASK   = 8'hFF;
   localparam logic [2:0]  STUFF_LIMIT = 3'd5;
   localparam logic [4:0]  BYTE_BITS   = 5'd8;
   localparam logic [4:0]  FCS_BITS    = 5'd16;

   typedef struct packed {
      logic load;
      logic send_bit;
      logic send_stuff;
   } ctrl_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic stuff_due;
      logic final_bit;
      logic all_sent;
   } dpath_stat_type;

endpackage
`default_nettype wire

// ===== rtl/ahbt_ctrl.sv =====
`default_nettype none
module ahbt_ctrl
   import ahbt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic [1:0]     req_command,
   output logic                req_ready,
   output ctrl_cmd_type        cmd,
   input  wire dpath_stat_type stat
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_BIT   = 3'b010,
      ST_STUFF = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      cmd_ok;

   assign cmd_ok = (req_command != CMD_NONE);

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.load       = 1'b0;
      cmd.send_bit   = 1'b0;
      cmd.send_stuff = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && cmd_ok) begin
               cmd.load = 1'b1;
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            if (stat.slot_free) begin
               cmd.send_bit = 1'b1;
               if (stat.stuff_due) begin
                  state_in = ST_STUFF;
               end else if (stat.final_bit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_STUFF: begin
            if (stat.slot_free) begin
               cmd.send_stuff = 1'b1;
               state_in = stat.all_sent ? ST_IDLE : ST_BIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ahbt_dpath.sv =====
`default_nettype none
module ahbt_dpath
   import ahbt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [1:0]   req_command,
   input  wire logic [7:0]   req_data_byte,
   input  wire ctrl_cmd_type cmd,
   output dpath_stat_type    stat,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_line_tone,
   output logic              rsp_stuffed,
   output logic              rsp_last
);

   logic [15:0] crc_ff, crc_in;
   logic [2:0]  ones_ff, ones_in;
   logic        tone_ff, tone_in;
   logic [15:0] shift_ff, shift_in;
   logic [4:0]  left_ff, left_in;
   logic        flag_ff, flag_in;
   logic        valid_ff, valid_in;
   logic        out_tone_ff, out_tone_in;
   logic        out_stuffed_ff, out_stuffed_in;
   logic        out_last_ff, out_last_in;
   logic        cur_bit;
   logic        mix;

   assign cur_bit = shift_ff[0];
   assign mix     = crc_ff[0] ^ cur_bit;

   assign stat.slot_free = !valid_ff || rsp_ready;
   assign stat.stuff_due = cur_bit && !flag_ff && (ones_ff == (STUFF_LIMIT - 3'd1));
   assign stat.final_bit = (left_ff == 5'd1);
   assign stat.all_sent  = (left_ff == 5'd0);

   always_comb begin
      crc_in         = crc_ff;
      ones_in        = ones_ff;
      tone_in        = tone_ff;
      shift_in       = shift_ff;
      left_in        = left_ff;
      flag_in        = flag_ff;
      valid_in       = valid_ff && !rsp_ready;
      out_tone_in    = out_tone_ff;
      out_stuffed_in = out_stuffed_ff;
      out_last_in    = out_last_ff;
      if (cmd.load) begin
         case (req_command)
            CMD_FLAG: begin
               shift_in = {8'h00, FLAG_BYTE};
               left_in  = BYTE_BITS;
               flag_in  = 1'b1;
               ones_in  = 3'd0;
               crc_in   = CRC_PRESET;
            end
            CMD_DATA: begin
               shift_in = {8'h00, req_data_byte};
               left_in  = BYTE_BITS;
               flag_in  = 1'b0;
            end
            CMD_FCS: begin
               shift_in = {crc_ff[15:8] ^ BYTE_MASK, crc_ff[7:0] ^ BYTE_MASK};
               left_in  = FCS_BITS;
               flag_in  = 1'b0;
            end
            default: begin
               flag_in = flag_ff;
            end
         endcase
      end
      if (cmd.send_bit) begin
         shift_in = {1'b0, shift_ff[15:1]};
         left_in  = left_ff - 5'd1;
         if (!cur_bit) begin
            tone_in = !tone_ff;
         end
         if (!flag_ff) begin
            crc_in = {1'b0, crc_ff[15:1]} ^ (mix ? CRC_POLY : 16'h0000);
            ones_in = cur_bit ? ones_ff + 3'd1 : 3'd0;
         end
         valid_in       = 1'b1;
         out_tone_in    = cur_bit ? tone_ff : !tone_ff;
         out_stuffed_in = 1'b0;
         out_last_in    = stat.final_bit && !stat.stuff_due;
      end
      if (cmd.send_stuff) begin
         tone_in        = !tone_ff;
         ones_in        = 3'd0;
         valid_in       = 1'b1;
         out_tone_in    = !tone_ff;
         out_stuffed_in = 1'b1;
         out_last_in    = stat.all_sent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_PRESET;
         ones_ff  <= 3'd0;
         tone_ff  <= 1'b0;
         valid_ff <= 1'b0;
         left_ff  <= 5'd0;
         flag_ff  <= 1'b0;
      end else begin
         crc_ff   <= crc_in;
         ones_ff  <= ones_in;
         tone_ff  <= tone_in;
         valid_ff <= valid_in;
         left_ff  <= left_in;
         flag_ff  <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff       <= shift_in;
      out_tone_ff    <= out_tone_in;
      out_stuffed_ff <= out_stuffed_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_line_tone = out_tone_ff;
   assign rsp_stuffed   = out_stuffed_ff;
   assign rsp_last      = out_last_ff;

endmodule
`default_nettype wire

// ===== rtl/ax25_hdlc_bit_transmitter.sv =====
// hdlc bit transmitter with bit stuffing, nrzi coding and crc-16 fcs
// input channel req_*: one word carries a command (flag, data, fcs) and a byte;
//    req_ready is high only while the block is idle, one word is worked at a time
// output channel rsp_*: one word per line bit time with the nrzi tone, a
//    stuffed marker and a last marker on the final bit time of an input word
// a flag gives 8 words, a data byte 8 to 10, an fcs 16 to 20 (stuffed zeros
//    follow every fifth one in a row outside flags)
// the first bit word is registered from the bit state that follows the load
// throughput: one bit word per cycle from the shift register and crc unit
//    while rsp_ready holds; each input word is also loaded in the idle state
// unused command code: taken while idle, no output, state unchanged
// a stalled receiver holds the output register; no bit is lost, the bit
//    stream simply pauses until rsp_ready returns
// reset: crc preset to all ones, ones count cleared, line tone low, idle
`default_nettype none
module ax25_hdlc_bit_transmitter
   import ahbt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_command,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_line_tone,
   output logic            rsp_stuffed,
   output logic            rsp_last
);

   ctrl_cmd_type   cmd;
   dpath_stat_type stat;

   ahbt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .cmd         (cmd),
      .stat        (stat)
   );

   ahbt_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_command   (req_command),
      .req_data_byte (req_data_byte),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_line_tone (rsp_line_tone),
      .rsp_stuffed   (rsp_stuffed),
      .rsp_last      (rsp_last)
   );

   a_busy_after_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command != CMD_NONE) |=> !req_ready)
      else $error("block took a word while busy");

   a_none_stays_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_NONE) |=> req_ready && !cmd.send_bit)
      else $error("unused command started a transfer");

   a_stuff_toggles: assert property (@(posedge clock) disable iff (reset)
      cmd.send_stuff |-> stat.slot_free && !req_ready)
      else $error("stuff bit sent into a full output register");

endmodule
`default_nettype wire

// ===== tb/hdlc_tx_tb_pkg.sv =====
`timescale 1ns / 1ps
package hdlc_tx_tb_pkg;
   import ahbt_pkg::*;

   typedef struct packed {
      logic tone;
      logic stuffed;
      logic last;
   } line_bit_type;

   class line_bit_scoreboard;
      logic [15:0]  crc_reg;
      logic [2:0]   ones_count;
      logic         tone_level;
      line_bit_type expected_bits[$];
      int           mismatches;

      function new();
         crc_reg    = CRC_PRESET;
         ones_count = '0;
         tone_level = 1'b0;
         mismatches = 0;
      endfunction

      function void note_mismatch(string what);
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch at %0t: %s", $realtime, what);
         end
      endfunction

      function void push_bit(logic stuffed);
         line_bit_type b;
         b.tone    = tone_level;
         b.stuffed = stuffed;
         b.last    = 1'b0;
         expected_bits.push_back(b);
      endfunction

      // lsb first, crc per bit, zero inserted after five ones
      function void shift_out_byte(logic [7:0] value);
         logic bit_in;
         logic mix;
         for (int i = 0; i < 8; i++) begin
            bit_in  = value[i];
            mix     = crc_reg[0] ^ bit_in;
            crc_reg = crc_reg >> 1;
            if (mix) begin
               crc_reg = crc_reg ^ CRC_POLY;
            end
            if (!bit_in) begin
               tone_level = ~tone_level;
               ones_count = '0;
               push_bit(1'b0);
            end else begin
               push_bit(1'b0);
               ones_count = ones_count + 3'd1;
               if (ones_count >= STUFF_LIMIT) begin
                  tone_level = ~tone_level;
                  ones_count = '0;
                  push_bit(1'b1);
               end
            end
         end
      endfunction

      function void note_word(cmd_code_type cmd, logic [7:0] value);
         int           start;
         logic [15:0]  fcs;
         line_bit_type tail;
         start = expected_bits.size();
         case (cmd)
            CMD_FLAG: begin
               for (int i = 0; i < 8; i++) begin
                  if (!FLAG_BYTE[i]) begin
                     tone_level = ~tone_level;
                  end
                  push_bit(1'b0);
               end
               ones_count = '0;
               crc_reg    = CRC_PRESET;
            end
            CMD_DATA: shift_out_byte(value);
            CMD_FCS: begin
               fcs = ~crc_reg;
               shift_out_byte(fcs[7:0]);
               shift_out_byte(fcs[15:8]);
            end
            default: ;
         endcase
         if (expected_bits.size() > start) begin
            tail      = expected_bits.pop_back();
            tail.last = 1'b1;
            expected_bits.push_back(tail);
         end
      endfunction

      function void check_word(logic tone, logic stuffed, logic last);
         line_bit_type want;
         if (expected_bits.size() == 0) begin
            note_mismatch($sformatf("unexpected word tone %b stuffed %b last %b",
                                    tone, stuffed, last));
            return;
         end
         want = expected_bits.pop_front();
         if (want.tone !== tone) begin
            note_mismatch($sformatf("line_tone expected %b got %b", want.tone, tone));
         end
         if (want.stuffed !== stuffed) begin
            note_mismatch($sformatf("stuffed expected %b got %b", want.stuffed, stuffed));
         end
         if (want.last !== last) begin
            note_mismatch($sformatf("last expected %b got %b", want.last, last));
         end
      endfunction
   endclass

endpackage

// ===== tb/tb_ax25_hdlc_bit_transmitter.sv =====
`timescale 1ns / 1ps
module tb_ax25_hdlc_bit_transmitter;
   import ahbt_pkg::*;
   import hdlc_tx_tb_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic [1:0] req_command   = CMD_FLAG;
   logic [7:0] req_data_byte = '0;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   logic       rsp_line_tone;
   logic       rsp_stuffed;
   logic       rsp_last;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_cycles  = 0;
   int items_sent    = 0;

   line_bit_scoreboard sb;

   ax25_hdlc_bit_transmitter dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_line_tone (rsp_line_tone),
      .rsp_stuffed   (rsp_stuffed),
      .rsp_last      (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_word(cmd_code_type'(req_command), req_data_byte);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_word(rsp_line_tone, rsp_stuffed, rsp_last);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(5))
         0: return 8'hFF;
         1: return FLAG_BYTE;
         2: return 8'h1F;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_word(cmd_code_type cmd, logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_data_byte <= value;
      do @(posedge clock); while (!req_ready);
      if (cmd != CMD_NONE) begin
         items_sent++;
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_bits.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_frame(int n_bytes);
      send_word(CMD_FLAG, 8'($urandom));
      repeat (n_bytes) begin
         send_word(CMD_DATA, pick_byte());
      end
      send_word(CMD_FCS, 8'($urandom));
   endtask

   task automatic run_phase(int n_items);
      int target;
      target = items_sent + n_items;
      while (items_sent < target) begin
         if ($urandom_range(9) == 0) begin
            // broken sequences: any command in any order, unused code included
            repeat ($urandom_range(1, 4)) begin
               send_word(cmd_code_type'($urandom_range(3)), pick_byte());
            end
         end else begin
            send_frame($urandom_range(1, 6));
         end
         if ($urandom_range(7) == 0) begin
            wait_for_drain();
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // fcs straight after reset, stuffing runs, flag byte as data, residue
      send_word(CMD_FCS,  8'h00);
      send_word(CMD_FLAG, 8'hFF);
      send_word(CMD_DATA, 8'h00);
      send_word(CMD_DATA, 8'hFF);
      send_word(CMD_DATA, 8'hFF);
      send_word(CMD_DATA, FLAG_BYTE);
      send_word(CMD_DATA, 8'hF8);
      send_word(CMD_FCS,  8'hFF);
      send_word(CMD_FCS,  8'h00);
      send_word(CMD_NONE, 8'hA5);
      send_word(CMD_DATA, 8'hFF);
      send_word(CMD_FLAG, 8'h00);
      send_word(CMD_FLAG, 8'h00);
      send_word(CMD_DATA, 8'h1F);
      send_word(CMD_DATA, 8'h80);
      send_word(CMD_NONE, 8'h5A);
      send_word(CMD_DATA, 8'h7F);
      send_word(CMD_FCS,  8'h00);
      send_word(CMD_FLAG, 8'h00);
      wait_for_drain();

      send_idle_pct = 19;
      recv_idle_pct = 53;
      run_phase(75);
      wait_for_drain();

      send_idle_pct = 53;
      recv_idle_pct = 19;
      run_phase(75);
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(70);
      wait_for_drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_bits.size() != 0) begin
         sb.note_mismatch($sformatf("%0d expected words never came",
                                    sb.expected_bits.size()));
      end
      if (sb.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== ax25_hdlc_bit_transmitter.f =====
rtl/ahbt_pkg.sv
rtl/ahbt_ctrl.sv
rtl/ahbt_dpath.sv
rtl/ax25_hdlc_bit_transmitter.sv
tb/hdlc_tx_tb_pkg.sv
tb/tb_ax25_hdlc_bit_transmitter.sv
